// File: hw/rtl/sn83_pkg.sv
// shared types, constants and helpers for the 8.3 short name encoder
package sn83_pkg;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_DELTA = 8'd32;

   localparam int BASE_DEPTH = 8;
   localparam int EXT_DEPTH  = 3;
   localparam int SHORT_LEN  = 11;
   localparam int TAIL_KEEP  = 6;

   localparam logic [3:0] POS_TILDE    = 4'd6;
   localparam logic [3:0] POS_EXT_BASE = 4'd8;
   localparam logic [3:0] POS_FINAL    = 4'(SHORT_LEN - 1);

   typedef struct packed {
      logic [7:0] name_char;
      logic       last_char;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic [3:0] out_pos;
      logic       out_last;
   } rsp_beat_type;

   typedef struct packed {
      logic load;
      logic step;
      logic clear;
   } sn83_cmd_type;

   typedef struct packed {
      logic pos_final;
   } sn83_status_type;

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
         r = c - CASE_DELTA;
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/sn83_ctrl.sv
// controller: collects name beats, then sequences the eleven output beats
module sn83_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_last,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  sn83_pkg::sn83_status_type status,
   output sn83_pkg::sn83_cmd_type    cmd
);
   import sn83_pkg::*;

   typedef enum logic {
      ST_COLLECT,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      req_stall = (state_ff != ST_COLLECT);
      rsp_valid = (state_ff == ST_EMIT);
      cmd.load  = req_valid && !req_stall;
      cmd.step  = rsp_valid && !rsp_stall;
      cmd.clear = cmd.step && status.pos_final;
      state_in  = state_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (cmd.load && req_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.clear) begin
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/sn83_datapath.sv
// datapath: name byte storage, dot tracking and output byte selection
module sn83_datapath #(
   parameter int LENGTH_LIMIT = 255
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sn83_pkg::sn83_cmd_type    cmd,
   input  sn83_pkg::req_beat_type    req_data,
   output sn83_pkg::rsp_beat_type    rsp_data,
   output sn83_pkg::sn83_status_type status
);
   import sn83_pkg::*;

   localparam int LEN_W = $clog2(LENGTH_LIMIT + 1);

   logic [7:0]       base_ff [BASE_DEPTH];
   logic [7:0]       ext_ff  [EXT_DEPTH];
   logic [1:0]       ext_count_ff;
   logic [1:0]       ext_count_in;
   logic [LEN_W-1:0] length_ff;
   logic [LEN_W-1:0] length_in;
   logic             dot_seen_ff;
   logic             dot_seen_in;
   logic [LEN_W-1:0] dot_pos_ff;
   logic [LEN_W-1:0] dot_pos_in;
   logic [3:0]       pos_ff;
   logic [3:0]       pos_in;

   logic [7:0]       up_char;
   logic             is_dot;
   logic             base_wr;
   logic             ext_wr;
   logic [LEN_W-1:0] base_len;
   logic             base_long;
   logic [1:0]       ext_idx;
   logic [7:0]       out_char;

   assign up_char = to_upper(req_data.name_char);
   assign is_dot  = (req_data.name_char == CHAR_DOT);
   assign base_wr = cmd.load && (length_ff < LEN_W'(BASE_DEPTH));
   assign ext_wr  = cmd.load && !is_dot && dot_seen_ff && (ext_count_ff < 2'(EXT_DEPTH));

   always_comb begin
      ext_count_in = ext_count_ff;
      length_in    = length_ff;
      dot_seen_in  = dot_seen_ff;
      dot_pos_in   = dot_pos_ff;
      pos_in       = pos_ff;
      if (cmd.load) begin
         if (is_dot) begin
            dot_seen_in  = 1'b1;
            dot_pos_in   = length_ff;
            ext_count_in = '0;
         end else if (ext_wr) begin
            ext_count_in = ext_count_ff + 2'd1;
         end
         if (length_ff < LEN_W'(LENGTH_LIMIT)) begin
            length_in = length_ff + LEN_W'(1);
         end
      end
      if (cmd.step) begin
         pos_in = status.pos_final ? 4'd0 : pos_ff + 4'd1;
      end
      if (cmd.clear) begin
         ext_count_in = '0;
         length_in    = '0;
         dot_seen_in  = 1'b0;
         dot_pos_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_count_ff <= '0;
         length_ff    <= '0;
         dot_seen_ff  <= 1'b0;
         dot_pos_ff   <= '0;
         pos_ff       <= '0;
      end else begin
         ext_count_ff <= ext_count_in;
         length_ff    <= length_in;
         dot_seen_ff  <= dot_seen_in;
         dot_pos_ff   <= dot_pos_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (base_wr) begin
         base_ff[length_ff[2:0]] <= up_char;
      end
      if (ext_wr) begin
         ext_ff[ext_count_ff] <= up_char;
      end
   end

   // output byte for the current position
   always_comb begin
      base_len  = dot_seen_ff ? dot_pos_ff : length_ff;
      base_long = (base_len > LEN_W'(BASE_DEPTH));
      ext_idx   = 2'(pos_ff - POS_EXT_BASE);
      out_char  = CHAR_SPACE;
      if (pos_ff < POS_EXT_BASE) begin
         if (base_long) begin
            if (pos_ff < 4'(TAIL_KEEP)) begin
               out_char = base_ff[pos_ff[2:0]];
            end else if (pos_ff == POS_TILDE) begin
               out_char = CHAR_TILDE;
            end else begin
               out_char = CHAR_ONE;
            end
         end else if (LEN_W'(pos_ff) < base_len) begin
            out_char = base_ff[pos_ff[2:0]];
         end
      end else if (dot_seen_ff && (ext_idx < ext_count_ff)) begin
         out_char = ext_ff[ext_idx];
      end
   end

   assign status.pos_final  = (pos_ff == POS_FINAL);
   assign rsp_data.out_char = out_char;
   assign rsp_data.out_pos  = pos_ff;
   assign rsp_data.out_last = status.pos_final;

endmodule

// File: hw/rtl/short_name_8_3_encoder.sv
// top level of the 8.3 short name encoder
// Usage:
//   req channel: one file name byte per beat (req_data.name_char), with
//   req_data.last_char set on the final byte of the name.
//   rsp channel: after the final byte, eleven beats carry the short name,
//   out_pos 0..7 for the base and 8..10 for the extension, out_last on the
//   eleventh beat.
// Timing:
//   the block takes one name byte per cycle while collecting.
//   the final byte is followed by eleven output beats, one per cycle while
//   rsp_stall is low, the first visible the cycle after the final byte.
//   req_stall is high while the short name is being sent.
// Reset: returns to collecting, with an empty name and no output pending.
// Stall: a stalled output beat holds its payload until taken; nothing is
//   accepted on req until the eleventh beat is taken.
module short_name_8_3_encoder #(
   parameter int LENGTH_LIMIT = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sn83_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sn83_pkg::rsp_beat_type rsp_data
);
   import sn83_pkg::*;

   sn83_cmd_type    cmd;
   sn83_status_type status;

   sn83_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_char),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sn83_datapath #(
      .LENGTH_LIMIT (LENGTH_LIMIT)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .status   (status)
   );

endmodule
